FILE: hdl/assert_macros.svh
// Assertion macros shared by the echo delay RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NORST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

FILE: hdl/edly_pkg.sv
// Types, constants and helpers shared by the echo delay modules.
package edly_pkg;
	localparam int SAMPLE_BITS = 16;
	localparam int DELAY_BITS = 17;
	localparam int FB_BITS = 15;
	localparam int WET_BITS = 16;
	localparam int FRAC_BITS = 15;
	localparam int PROD_BITS = SAMPLE_BITS + WET_BITS + 2;
	localparam int RING_DEPTH_DEF = 131072;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = DELAY_BITS;
	localparam int SETTLE_BITS = 2;

	localparam logic [DELAY_BITS-1:0] DELAY_RST = DELAY_BITS'(24000);
	localparam logic [FB_BITS-1:0] FB_RST = FB_BITS'(13107);
	localparam logic [WET_BITS-1:0] WET_RST = WET_BITS'(16384);
	localparam logic [WET_BITS-1:0] Q_ONE = WET_BITS'(32768);
	localparam logic signed [PROD_BITS-1:0] Q_HALF = PROD_BITS'(16384);
	localparam logic signed [PROD_BITS-1:0] SAT_HI =
		PROD_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [PROD_BITS-1:0] SAT_LO = -SAT_HI - PROD_BITS'(1);
	localparam logic [SETTLE_BITS-1:0] SETTLE_CYCLES = SETTLE_BITS'(2);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_DELAY = 2'd0,
		CFG_FEEDBACK = 2'd1,
		CFG_WET = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [FB_BITS-1:0] fb;
		logic [WET_BITS-1:0] wet;
		logic [WET_BITS-1:0] dry;
	} gain_t;

	typedef struct packed {
		logic filled;
		logic busy;
	} addr_stat_t;

	function automatic sample_t sat_sample(input logic signed [PROD_BITS-1:0] v);
		sample_t r;
		if (v > SAT_HI) begin
			r = SAT_HI[SAMPLE_BITS-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			r = v[SAMPLE_BITS-1:0];
		end
		return r;
	endfunction
endpackage

FILE: hdl/edly_ring.sv
// One channel's delay ring: a single-port-write, registered-read sample memory.
module edly_ring #(
	parameter int RING_DEPTH = edly_pkg::RING_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [$clog2(RING_DEPTH)-1:0]         waddr,
	input  logic signed [edly_pkg::SAMPLE_BITS-1:0] wdata,
	input  logic                                  re,
	input  logic [$clog2(RING_DEPTH)-1:0]         raddr,
	output logic signed [edly_pkg::SAMPLE_BITS-1:0] rdata
);
	import edly_pkg::*;

	sample_t mem_q [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: hdl/edly_chan.sv
// Per-channel arithmetic: dry/wet mix and feedback sum, both rounded and saturated.
module edly_chan (
	input  logic signed [edly_pkg::SAMPLE_BITS-1:0] x,
	input  logic signed [edly_pkg::SAMPLE_BITS-1:0] d,
	input  edly_pkg::gain_t                         gain,
	output logic signed [edly_pkg::SAMPLE_BITS-1:0] mixed,
	output logic signed [edly_pkg::SAMPLE_BITS-1:0] fed
);
	import edly_pkg::*;

	logic signed [WET_BITS:0] dry_s;
	logic signed [WET_BITS:0] wet_s;
	logic signed [FB_BITS:0] fb_s;
	logic signed [PROD_BITS-1:0] p_dry;
	logic signed [PROD_BITS-1:0] p_wet;
	logic signed [PROD_BITS-1:0] p_fb;
	logic signed [PROD_BITS-1:0] mix_sum;
	logic signed [PROD_BITS-1:0] fb_sh;
	logic signed [PROD_BITS-1:0] fed_sum;

	assign dry_s = {1'b0, gain.dry};
	assign wet_s = {1'b0, gain.wet};
	assign fb_s = {1'b0, gain.fb};
	assign p_dry = PROD_BITS'(x) * PROD_BITS'(dry_s);
	assign p_wet = PROD_BITS'(d) * PROD_BITS'(wet_s);
	assign p_fb = PROD_BITS'(d) * PROD_BITS'(fb_s);
	assign mix_sum = (p_dry + p_wet + Q_HALF) >>> FRAC_BITS;
	assign fb_sh = (p_fb + Q_HALF) >>> FRAC_BITS;
	assign fed_sum = PROD_BITS'(x) + fb_sh;
	assign mixed = sat_sample(mix_sum);
	assign fed = sat_sample(fed_sum);
endmodule

FILE: hdl/edly_addr.sv
// Write slot, delay-modulo-depth offset, read address and ring fill tracking.
module edly_addr #(
	parameter int RING_DEPTH = edly_pkg::RING_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [edly_pkg::DELAY_BITS-1:0]      delay,
	input  logic                                 delay_wr,
	input  logic                                 advance,
	output logic [$clog2(RING_DEPTH)-1:0]        rd_addr,
	output logic [$clog2(RING_DEPTH)-1:0]        wr_addr,
	output edly_pkg::addr_stat_t                 stat
);
	import edly_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);
	localparam int SH = DELAY_BITS + AW;
	localparam int RW = DELAY_BITS + 2;
	localparam int PW = SH + DELAY_BITS;
	localparam int QW = DELAY_BITS + AW + 1;
	localparam longint unsigned RECIP =
		((64'd1 << SH) + longint'(RING_DEPTH) - 64'd1) / RING_DEPTH;
	localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
	localparam logic [AW:0] DEPTH_V = (AW + 1)'(RING_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

	logic [PW-1:0] prod;
	logic [DELAY_BITS-1:0] quo_q;
	logic [QW-1:0] rem;
	logic [AW-1:0] back_q;
	logic [AW:0] diff;
	logic [AW-1:0] ws_q;
	logic wrapped_q;
	logic [SETTLE_BITS-1:0] settle_q;

	// Delay modulo depth by reciprocal multiplication; exact for every 17-bit delay.
	assign prod = PW'(delay) * PW'(RECIP_V);
	assign rem = QW'(delay) - QW'(quo_q) * QW'(RING_DEPTH);

	always_ff @(posedge clk) begin
		quo_q <= prod[SH +: DELAY_BITS];
		back_q <= rem[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_CYCLES;
			ws_q <= '0;
			wrapped_q <= 1'b0;
		end else begin
			if (delay_wr) begin
				settle_q <= SETTLE_CYCLES;
			end else if (settle_q != '0) begin
				settle_q <= settle_q - SETTLE_BITS'(1);
			end
			if (advance) begin
				if (ws_q == LAST_SLOT) begin
					ws_q <= '0;
					wrapped_q <= 1'b1;
				end else begin
					ws_q <= ws_q + AW'(1);
				end
			end
		end
	end

	assign diff = {1'b0, ws_q} - {1'b0, back_q};
	assign rd_addr = diff[AW] ? diff[AW-1:0] + DEPTH_V[AW-1:0] : diff[AW-1:0];
	assign wr_addr = ws_q;
	// A slot holds written data once the ring has wrapped or it lies below the write slot.
	assign stat.filled = wrapped_q || (rd_addr < ws_q);
	assign stat.busy = (settle_q != '0);
endmodule

FILE: hdl/stereo_feedback_echo_delay_core.sv
// Stereo feedback echo core: config registers, request pipeline and two delay rings.
// A request is registered into stage 1 with its ring read, then its result into the output register once it advances.
// Throughput: one stereo request per cycle unless output or settling stalls; one ring read and one write per channel.
// After reset and after each delay write, requests are held off while the settle counter runs down.
// Reset clears control state; ring slots read as zero until first written.
`include "assert_macros.svh"
module stereo_feedback_echo_delay_core #(
	parameter int RING_DEPTH = edly_pkg::RING_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [edly_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
	input  logic [edly_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [2*edly_pkg::SAMPLE_BITS-1:0]  s_tdata,  // in_left, in_right
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [2*edly_pkg::SAMPLE_BITS-1:0]  m_tdata   // out_left, out_right
);
	import edly_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);

	logic [DELAY_BITS-1:0] delay_q;
	logic [FB_BITS-1:0] fb_q;
	logic [WET_BITS-1:0] wet_q;
	logic [WET_BITS-1:0] wet_eff;
	gain_t gain;
	logic delay_wr;

	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	addr_stat_t stat;

	logic s_accept;
	logic adv;
	logic s1_valid_q;
	sample_t x_l_s1, x_r_s1;
	logic [AW-1:0] ws_s1;
	logic filled_s1;
	logic byp_s1;
	sample_t byp_l_s1, byp_r_s1;
	sample_t rd_l, rd_r;
	sample_t d_l, d_r;
	sample_t mix_l, mix_r;
	sample_t fed_l, fed_r;
	logic m_tvalid_q;
	logic [2*SAMPLE_BITS-1:0] m_tdata_q;

	assign delay_wr = cfg_we && (cfg_idx == CFG_DELAY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RST;
			fb_q <= FB_RST;
			wet_q <= WET_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_DELAY: delay_q <= cfg_data[DELAY_BITS-1:0];
				CFG_FEEDBACK: fb_q <= cfg_data[FB_BITS-1:0];
				CFG_WET: wet_q <= cfg_data[WET_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Wet fractions above unity are treated as fully wet.
	assign wet_eff = (wet_q > Q_ONE) ? Q_ONE : wet_q;
	assign gain.fb = fb_q;
	assign gain.wet = wet_eff;
	assign gain.dry = Q_ONE - wet_eff;

	assign adv = s1_valid_q && (!m_tvalid_q || m_tready);
	assign s_tready = !stat.busy && (!s1_valid_q || adv);
	assign s_accept = s_tvalid && s_tready;

	edly_addr #(.RING_DEPTH(RING_DEPTH)) u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.delay    (delay_q),
		.delay_wr (delay_wr),
		.advance  (s_accept),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.stat     (stat)
	);

	edly_ring #(.RING_DEPTH(RING_DEPTH)) u_ring_l (
		.clk   (clk),
		.we    (adv),
		.waddr (ws_s1),
		.wdata (fed_l),
		.re    (s_accept),
		.raddr (rd_addr),
		.rdata (rd_l)
	);

	edly_ring #(.RING_DEPTH(RING_DEPTH)) u_ring_r (
		.clk   (clk),
		.we    (adv),
		.waddr (ws_s1),
		.wdata (fed_r),
		.re    (s_accept),
		.raddr (rd_addr),
		.rdata (rd_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_accept) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// A ring write landing on the same edge as the read is forwarded to the new request.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			x_l_s1 <= s_tdata[SAMPLE_BITS-1:0];
			x_r_s1 <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
			ws_s1 <= wr_addr;
			filled_s1 <= stat.filled;
			byp_s1 <= adv && (ws_s1 == rd_addr);
			byp_l_s1 <= fed_l;
			byp_r_s1 <= fed_r;
		end
		if (adv) begin
			m_tdata_q <= {mix_r, mix_l};
		end
	end

	assign d_l = !filled_s1 ? '0 : (byp_s1 ? byp_l_s1 : rd_l);
	assign d_r = !filled_s1 ? '0 : (byp_s1 ? byp_r_s1 : rd_r);

	edly_chan u_chan_l (
		.x     (x_l_s1),
		.d     (d_l),
		.gain  (gain),
		.mixed (mix_l),
		.fed   (fed_l)
	);

	edly_chan u_chan_r (
		.x     (x_r_s1),
		.d     (d_r),
		.gain  (gain),
		.mixed (mix_r),
		.fed   (fed_r)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	`ASSERT_RST(a_no_slot_clash, clk, arst_n, s_accept && adv |-> ws_s1 != wr_addr, "pending write hits new slot")
	`ASSERT_RST(a_out_from_s1, clk, arst_n, $rose(m_tvalid_q) |-> $past(s1_valid_q), "output without a request")
	`ASSERT_RST(a_byp_filled, clk, arst_n, s1_valid_q && byp_s1 |-> filled_s1, "forwarded slot not filled")
endmodule

FILE: verif/tb_stereo_feedback_echo_delay_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stereo feedback echo core: predicts every frame and compares.
module tb_stereo_feedback_echo_delay_core;
	import edly_pkg::*;

	localparam int DEPTH = RING_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 20000;
	localparam int IDLE_PCT = 36;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_FRAMES = 100;
	localparam int ZERO_DELAY_FRAMES = 24;
	localparam int MAX_PRINTED = 40;
	localparam longint S_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint S_MIN = -S_MAX - 1;
	localparam sample_t SMP_MAX = sample_t'(S_MAX);
	localparam sample_t SMP_MIN = sample_t'(S_MIN);
	localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = CFG_IDX_BITS'(3);
	localparam logic [CFG_DATA_BITS-1:0] DELAY_MAX = CFG_DATA_BITS'(131071);
	localparam logic [CFG_DATA_BITS-1:0] FB_MAX = CFG_DATA_BITS'(31130);
	localparam logic [CFG_DATA_BITS-1:0] WET_FULL = CFG_DATA_BITS'(32768);
	localparam logic [CFG_DATA_BITS-1:0] WET_OVER_UNITY = CFG_DATA_BITS'(17'h1FFFF);
	localparam logic [CFG_DATA_BITS-1:0] FB_WIDE = CFG_DATA_BITS'(17'h1F99A);

	typedef struct {
		sample_t left;
		sample_t right;
	} frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [2*SAMPLE_BITS-1:0] s_tdata = '0;  // in_left, in_right
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [2*SAMPLE_BITS-1:0] m_tdata;  // out_left, out_right

	sample_t left_hist [DEPTH];
	sample_t right_hist [DEPTH];
	int unsigned head;
	logic [DELAY_BITS-1:0] echo_delay;
	logic [FB_BITS-1:0] echo_fb;
	logic [WET_BITS-1:0] echo_wet;

	frame_t pending_frames [$];
	int errors = 0;
	int frames_sent = 0;
	int frames_checked = 0;
	int settings_applied = 0;
	int cycle_count = 0;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;

	stereo_feedback_echo_delay_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_frames.size());
			$display("tb_stereo_feedback_echo_delay_core: FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= MAX_PRINTED) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
	endtask

	function automatic sample_t clip(input longint v);
		if (v > S_MAX) begin
			return SMP_MAX;
		end
		if (v < S_MIN) begin
			return SMP_MIN;
		end
		return sample_t'(v);
	endfunction

	function automatic longint round_q15(input longint acc);
		return (acc + longint'(16384)) >>> FRAC_BITS;
	endfunction

	function automatic frame_t predict_echo(input sample_t l, input sample_t r);
		frame_t res;
		int unsigned tap;
		longint wet;
		longint dry;
		longint fb;
		longint dl;
		longint dr;
		tap = (head + DEPTH - (int'(echo_delay) % DEPTH)) % DEPTH;
		wet = (echo_wet > Q_ONE) ? longint'(Q_ONE) : longint'(echo_wet);
		dry = longint'(Q_ONE) - wet;
		fb = longint'(echo_fb);
		dl = longint'(left_hist[tap]);
		dr = longint'(right_hist[tap]);
		res.left = clip(round_q15(longint'(l) * dry + dl * wet));
		res.right = clip(round_q15(longint'(r) * dry + dr * wet));
		left_hist[head] = clip(longint'(l) + round_q15(dl * fb));
		right_hist[head] = clip(longint'(r) + round_q15(dr * fb));
		head = (head + 1) % DEPTH;
		return res;
	endfunction

	function automatic sample_t rand_sample();
		case ($urandom_range(15))
			0: return SMP_MAX;
			1: return SMP_MIN;
			2: return sample_t'(0);
			3: return sample_t'(-1);
			default: return sample_t'($urandom);
		endcase
	endfunction

	always @(posedge clk) begin
		frame_t want;
		sample_t got_l;
		sample_t got_r;
		got_l = m_tdata[SAMPLE_BITS-1:0];
		got_r = m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_frames.size() == 0) begin
				report_mismatch($sformatf("result %0d/%0d with no prediction waiting",
					got_l, got_r));
			end else begin
				want = pending_frames.pop_front();
				if (got_l !== want.left) begin
					report_mismatch($sformatf("frame %0d out_left got %0d want %0d",
						frames_checked, got_l, want.left));
				end
				if (got_r !== want.right) begin
					report_mismatch($sformatf("frame %0d out_right got %0d want %0d",
						frames_checked, got_r, want.right));
				end
				frames_checked++;
			end
		end
		m_tready <= !rx_idle_en || ($urandom_range(99) >= IDLE_PCT);
	end

	// One request is accepted per handshake; the prediction is made at that edge.
	task automatic send_frame(input sample_t l, input sample_t r);
		if (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {r, l};
		do @(posedge clk); while (!s_tready);
		pending_frames.push_back(predict_echo(l, r));
		frames_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_DELAY: echo_delay = val[DELAY_BITS-1:0];
			CFG_FEEDBACK: echo_fb = val[FB_BITS-1:0];
			CFG_WET: echo_wet = val[WET_BITS-1:0];
			default: ;
		endcase
		settings_applied++;
	endtask

	task automatic test_reset_defaults();
		send_frame(SMP_MAX, SMP_MIN);
		send_frame(SMP_MIN, SMP_MAX);
		send_frame(sample_t'(0), sample_t'(0));
		send_frame(sample_t'(-1), sample_t'(1));
		send_frame(sample_t'(1), sample_t'(-1));
		drain_results();
	endtask

	task automatic test_saturation_extremes();
		write_reg(CFG_DELAY, CFG_DATA_BITS'(1));
		write_reg(CFG_FEEDBACK, FB_MAX);
		write_reg(CFG_WET, WET_FULL);
		for (int i = 0; i < 4; i++) begin
			send_frame(SMP_MAX, SMP_MIN);
		end
		for (int i = 0; i < 4; i++) begin
			send_frame(SMP_MIN, SMP_MAX);
		end
		drain_results();
		write_reg(CFG_WET, '0);
		send_frame(SMP_MAX, SMP_MIN);
		send_frame(sample_t'(-1), sample_t'(1));
		drain_results();
	endtask

	task automatic test_wet_clamp_and_masking();
		write_reg(CFG_WET, WET_OVER_UNITY);
		write_reg(CFG_FEEDBACK, FB_WIDE);
		send_frame(SMP_MAX, SMP_MAX);
		send_frame(SMP_MIN, SMP_MIN);
		send_frame(sample_t'(12345), sample_t'(-12345));
		send_frame(sample_t'(0), sample_t'(0));
		drain_results();
	endtask

	task automatic test_ignored_index();
		write_reg(CFG_UNMAPPED, CFG_DATA_BITS'(17'h0AAAA));
		write_reg(CFG_UNMAPPED, CFG_DATA_BITS'(17'h15555));
		send_frame(sample_t'(-20000), sample_t'(20000));
		send_frame(sample_t'(7), sample_t'(-7));
		drain_results();
	endtask

	task automatic test_delay_extremes();
		write_reg(CFG_DELAY, DELAY_MAX);
		write_reg(CFG_WET, CFG_DATA_BITS'(24576));
		send_frame(SMP_MAX, SMP_MIN);
		send_frame(sample_t'(100), sample_t'(-100));
		drain_results();
		write_reg(CFG_DELAY, '0);
		send_frame(SMP_MIN, SMP_MAX);
		send_frame(sample_t'(-100), sample_t'(100));
		drain_results();
	endtask

	task automatic apply_random_setting();
		logic [CFG_DATA_BITS-1:0] d;
		logic [FB_BITS-1:0] fb;
		logic [WET_BITS-1:0] wet;
		case ($urandom_range(7))
			0: d = '0;
			1: d = DELAY_MAX;
			2: d = CFG_DATA_BITS'($urandom_range(0, 131071));
			default: d = CFG_DATA_BITS'($urandom_range(1, 48));
		endcase
		case ($urandom_range(3))
			0: fb = '0;
			1: fb = FB_BITS'(FB_MAX);
			default: fb = FB_BITS'($urandom_range(0, 31130));
		endcase
		case ($urandom_range(5))
			0: wet = '0;
			1: wet = WET_BITS'(WET_FULL);
			2: wet = WET_BITS'($urandom_range(32769, 65535));
			default: wet = WET_BITS'($urandom_range(0, 32768));
		endcase
		write_reg(CFG_DELAY, d);
		write_reg(CFG_FEEDBACK, {2'($urandom), fb});
		write_reg(CFG_WET, {1'($urandom), wet});
		if ($urandom_range(3) == 0) begin
			write_reg(CFG_UNMAPPED, CFG_DATA_BITS'($urandom));
		end
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			tx_idle_en = (p != 3);
			rx_idle_en = (p != 3);
			apply_random_setting();
			for (int i = 0; i < PHASE_FRAMES; i++) begin
				send_frame(rand_sample(), rand_sample());
			end
			drain_results();
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// With zero delay each read lands on a slot not yet written in this pass of the ring.
	task automatic test_zero_delay_fresh_slots();
		write_reg(CFG_DELAY, '0);
		write_reg(CFG_WET, CFG_DATA_BITS'($urandom_range(16384, 32768)));
		write_reg(CFG_FEEDBACK, CFG_DATA_BITS'($urandom_range(0, 31130)));
		for (int i = 0; i < ZERO_DELAY_FRAMES; i++) begin
			send_frame(rand_sample(), rand_sample());
		end
		drain_results();
	endtask

	initial begin
		foreach (left_hist[i]) begin
			left_hist[i] = '0;
			right_hist[i] = '0;
		end
		head = 0;
		echo_delay = DELAY_RST;
		echo_fb = FB_RST;
		echo_wet = WET_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_saturation_extremes();
		test_wet_clamp_and_masking();
		test_ignored_index();
		test_delay_extremes();
		test_random_settings();
		test_zero_delay_fresh_slots();
		drain_results();
		repeat (8) @(posedge clk);
		$display("Sent %0d frames and checked %0d results over %0d register writes.",
			frames_sent, frames_checked, settings_applied);
		$display("Covered saturation, wet clamping, masked and ignored writes, and zero delay.");
		if (errors == 0) begin
			$display("tb_stereo_feedback_echo_delay_core: PASS");
		end else begin
			$display("%0d mismatches found.", errors);
			$display("tb_stereo_feedback_echo_delay_core: FAIL");
		end
		$finish;
	end
endmodule
